FILE: hdl/rsa_pkg.sv
// Shared constants and types for the RSA modexp unit.
// No dependencies.
package rsa_pkg;
  localparam int WORD_BITS = 64;
  localparam int CNT_BITS  = $clog2(WORD_BITS);
  localparam int IDX_BITS  = 2;

  localparam logic [IDX_BITS-1:0] REG_MODULUS = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_PUB_EXP = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_PRV_EXP = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  // request to the modular multiplier: addend operand a, scanned operand b
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mm_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;
endpackage

FILE: hdl/rsa_modexp_encrypt_decrypt_unit.sv
// RSA encrypt-then-decrypt unit: ciphertext = m^e mod n, decrypted = c^d mod n.
// Each beat runs two exponentiations on one shared bit-serial multiplier.
// One item in flight; two more may wait in the input queue. Sequential: next
// item starts after the last.
// Synchronous active-low reset: queue and output empty, modulus 1, exponents 0.
module rsa_modexp_encrypt_decrypt_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rsa_pkg::WORD_BITS-1:0] in_message,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rsa_pkg::WORD_BITS-1:0] out_ciphertext,
  output logic [rsa_pkg::WORD_BITS-1:0] out_decrypted,
  input  logic                          cfg_we,
  input  logic [rsa_pkg::IDX_BITS-1:0]  cfg_index,
  input  logic [rsa_pkg::WORD_BITS-1:0] cfg_wdata
);
  rsa_pkg::word_t    modulus_r, pub_r, prv_r;
  rsa_pkg::word_t    q_data, mm_prod;
  logic              q_valid, q_pop;
  rsa_pkg::q_stat_t  q_stat;
  rsa_pkg::mm_req_t  mm_req;
  rsa_pkg::mm_stat_t mm_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= rsa_pkg::WORD_BITS'(1);
      pub_r     <= '0;
      prv_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rsa_pkg::REG_MODULUS: modulus_r <= cfg_wdata;
        rsa_pkg::REG_PUB_EXP: pub_r     <= cfg_wdata;
        rsa_pkg::REG_PRV_EXP: prv_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rsa_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_message,
    .q_valid, .q_pop, .q_data, .q_stat
  );

  rsa_mulmod u_mulmod (
    .clk, .rst_n, .modulus(modulus_r), .req(mm_req), .stat(mm_stat), .prod(mm_prod)
  );

  rsa_engine u_engine (
    .clk, .rst_n, .pub_exp(pub_r), .prv_exp(prv_r),
    .q_valid, .q_pop, .q_data, .mm_req, .mm_stat, .mm_prod,
    .out_valid, .out_ready, .out_ciphertext, .out_decrypted
  );

  a_q_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mm_req.start && !mm_stat.busy |=> mm_stat.busy)
    else $error("multiplier did not start");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    mm_stat.done |=> !mm_stat.done)
    else $error("multiplier done longer than one cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mm_stat.done |-> !mm_stat.busy)
    else $error("multiplier done while busy");
endmodule

FILE: hdl/rsa_front.sv
// Input side: takes message beats into a two-entry queue.
// Depends on rsa_pkg.
module rsa_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rsa_pkg::word_t    in_message,
  output logic              q_valid,
  input  logic              q_pop,
  output rsa_pkg::word_t    q_data,
  output rsa_pkg::q_stat_t  q_stat
);
  rsa_pkg::word_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_data   = mem_r[rp_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_message;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end
endmodule

FILE: hdl/rsa_mulmod.sv
// Bit-serial modular multiplier: one bit of b per cycle, MSB first.
// Modulus zero means 2^WORD_BITS (plain wrap). Depends on rsa_pkg.
module rsa_mulmod (
  input  logic               clk,
  input  logic               rst_n,
  input  rsa_pkg::word_t     modulus,
  input  rsa_pkg::mm_req_t   req,
  output rsa_pkg::mm_stat_t  stat,
  output rsa_pkg::word_t     prod
);
  localparam int W = rsa_pkg::WORD_BITS;

  rsa_pkg::word_t acc_r, a_r, b_r;
  logic [rsa_pkg::CNT_BITS-1:0] cnt_r;
  logic busy_r, done_r;
  logic [W+1:0] t, t1, t2, n1, n2;
  rsa_pkg::word_t acc_nxt;
  logic nz;

  assign nz = (modulus != '0);
  assign n1 = {2'b00, modulus};
  assign n2 = {1'b0, modulus, 1'b0};
  // acc < n and a < n, so 2*acc + a < 3n: at most two subtractions
  assign t  = {1'b0, acc_r, 1'b0} + (b_r[W-1] ? {2'b00, a_r} : '0);
  assign t1 = t - n1;
  assign t2 = t - n2;

  always_comb begin
    if (!nz)          acc_nxt = t[W-1:0];
    else if (t >= n2) acc_nxt = t2[W-1:0];
    else if (t >= n1) acc_nxt = t1[W-1:0];
    else              acc_nxt = t[W-1:0];
  end

  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rsa_pkg::CNT_BITS'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      acc_r <= '0;
      // addend is 1 or already reduced; only 1 vs modulus 1 needs this
      a_r   <= (nz && req.a >= modulus) ? req.a - modulus : req.a;
      b_r   <= req.b;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[W-2:0], 1'b0};
    end
  end
endmodule

FILE: hdl/rsa_engine.sv
// Back end: sequences two right-to-left exponentiations on the multiplier
// and holds the result beat. Depends on rsa_pkg.
module rsa_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  rsa_pkg::word_t     pub_exp,
  input  rsa_pkg::word_t     prv_exp,
  input  logic               q_valid,
  output logic               q_pop,
  input  rsa_pkg::word_t     q_data,
  output rsa_pkg::mm_req_t   mm_req,
  input  rsa_pkg::mm_stat_t  mm_stat,
  input  rsa_pkg::word_t     mm_prod,
  output logic               out_valid,
  input  logic               out_ready,
  output rsa_pkg::word_t     out_ciphertext,
  output rsa_pkg::word_t     out_decrypted
);
  typedef enum logic [2:0] {S_IDLE, S_RED, S_CHK, S_MUL, S_SQR, S_OUT} state_t;

  state_t state_r;
  rsa_pkg::word_t base_r, exp_r, res_r, ct_r, opa_r, opb_r;
  logic enc_r, vld_r, start_r, issue;
  rsa_pkg::word_t one_w;

  assign one_w        = rsa_pkg::WORD_BITS'(1);
  assign q_pop        = (state_r == S_IDLE) && q_valid;
  assign mm_req.start = start_r;
  assign mm_req.a     = opa_r;
  assign mm_req.b     = opb_r;
  assign out_valid    = vld_r;

  // states that hand a new product to the multiplier on the next cycle
  always_comb begin
    case (state_r)
      S_IDLE:  issue = q_valid;
      S_CHK:   issue = (exp_r != '0) || enc_r;
      S_MUL:   issue = mm_stat.done && ((exp_r >> 1) != '0);
      default: issue = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= 1'b0;
      start_r <= 1'b0;
      enc_r   <= 1'b0;
    end else begin
      start_r <= issue;
      if (state_r == S_OUT && (!vld_r || out_ready)) vld_r <= 1'b1;
      else if (out_ready)                            vld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            base_r  <= q_data;
            exp_r   <= pub_exp;
            res_r   <= one_w;
            enc_r   <= 1'b1;
            opa_r   <= one_w;
            opb_r   <= q_data;
            state_r <= S_RED;
          end
        end
        S_RED: begin
          if (mm_stat.done) begin
            base_r  <= mm_prod;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (exp_r == '0) begin
            if (enc_r) begin
              ct_r    <= res_r;
              base_r  <= res_r;
              res_r   <= one_w;
              exp_r   <= prv_exp;
              enc_r   <= 1'b0;
              opa_r   <= one_w;
              opb_r   <= res_r;
              state_r <= S_RED;
            end else begin
              state_r <= S_OUT;
            end
          end else if (exp_r[0]) begin
            opa_r   <= res_r;
            opb_r   <= base_r;
            state_r <= S_MUL;
          end else begin
            exp_r   <= exp_r >> 1;
            opa_r   <= base_r;
            opb_r   <= base_r;
            state_r <= S_SQR;
          end
        end
        S_MUL: begin
          if (mm_stat.done) begin
            res_r <= mm_prod;
            exp_r <= exp_r >> 1;
            if ((exp_r >> 1) == '0) begin
              state_r <= S_CHK;
            end else begin
              opa_r   <= base_r;
              opb_r   <= base_r;
              state_r <= S_SQR;
            end
          end
        end
        S_SQR: begin
          if (mm_stat.done) begin
            base_r  <= mm_prod;
            state_r <= S_CHK;
          end
        end
        S_OUT: begin
          if (!vld_r || out_ready) begin
            out_ciphertext <= ct_r;
            out_decrypted  <= res_r;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: dv/tb_rsa_modexp_encrypt_decrypt_unit.sv
// Testbench for rsa_modexp_encrypt_decrypt_unit: directed key/message table, then
// random keys and messages, scored against typed values or an in-bench modexp predictor.
// Depends on hdl/rsa_pkg.sv and the unit's RTL.
module tb_rsa_modexp_encrypt_decrypt_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  rsa_pkg::word_t               in_message = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  rsa_pkg::word_t               out_ciphertext;
  rsa_pkg::word_t               out_decrypted;
  logic                         cfg_we = 1'b0;
  logic [rsa_pkg::IDX_BITS-1:0] cfg_index = rsa_pkg::REG_MODULUS;
  rsa_pkg::word_t               cfg_wdata = '0;

  rsa_modexp_encrypt_decrypt_unit uut (.*);

  always #10 clk = ~clk;

  typedef struct {
    rsa_pkg::word_t c;
    rsa_pkg::word_t m;
  } rsa_pair_t;

  typedef struct {
    bit             rekey;
    rsa_pkg::word_t n;
    rsa_pkg::word_t e;
    rsa_pkg::word_t d;
    rsa_pkg::word_t msg;
    bit             known;
    rsa_pkg::word_t c;
    rsa_pkg::word_t m;
  } key_row_t;

  rsa_pair_t      pending_q[$];
  rsa_pkg::word_t key_n = 64'd1, key_e = '0, key_d = '0;
  int             errors = 0;
  int             results_seen = 0;
  bit             calm = 1'b0;
  bit             held = 1'b0;

  // n == 0 stands for 2^64: plain wrap
  function automatic rsa_pkg::word_t modmul(rsa_pkg::word_t a, rsa_pkg::word_t b,
                                            rsa_pkg::word_t n);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (n == '0) return p[63:0];
    p = p % {64'd0, n};
    return p[63:0];
  endfunction

  // right-to-left square-and-multiply; zero exponent gives an unreduced 1
  function automatic rsa_pkg::word_t modexp(rsa_pkg::word_t base, rsa_pkg::word_t ex,
                                            rsa_pkg::word_t n);
    rsa_pkg::word_t r;
    r = 64'd1;
    while (ex != '0) begin
      if (ex[0]) r = modmul(r, base, n);
      ex = ex >> 1;
      base = modmul(base, base, n);
    end
    return r;
  endfunction

  function automatic rsa_pair_t predict_pair(rsa_pkg::word_t msg);
    rsa_pair_t p;
    p.c = modexp(msg, key_e, key_n);
    p.m = modexp(p.c, key_d, key_n);
    return p;
  endfunction

  task automatic write_reg(logic [rsa_pkg::IDX_BITS-1:0] idx, rsa_pkg::word_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic load_key(rsa_pkg::word_t n, rsa_pkg::word_t e, rsa_pkg::word_t d);
    wait (pending_q.size() == 0);
    repeat (4) @(negedge clk);
    write_reg(rsa_pkg::REG_MODULUS, n);
    write_reg(rsa_pkg::REG_PUB_EXP, e);
    write_reg(rsa_pkg::REG_PRV_EXP, d);
    @(negedge clk);
    cfg_we <= 1'b0;
    key_n = n;
    key_e = e;
    key_d = d;
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  // valid stays high across back-to-back beats; only lowered ahead of a gap
  task automatic send_msg(rsa_pkg::word_t msg, bit known, rsa_pair_t typed);
    int gap;
    rsa_pair_t p;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_message <= msg;
    do @(posedge clk); while (!in_ready);
    p = known ? typed : predict_pair(msg);
    pending_q.push_back(p);
  endtask

  // receiver: random stalls, one long hold-off to back the unit up
  initial begin
    int r;
    wait (rst_n);
    forever begin
      if (!held && results_seen >= 20) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (40000) @(negedge clk);
        held = 1'b1;
      end
      r = $urandom_range(0, 99);
      @(negedge clk);
      out_ready <= calm || (r >= 25);
      if (!calm && r < 3) repeat ($urandom_range(20, 300)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    rsa_pair_t x;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat c=%h m=%h", $time, out_ciphertext, out_decrypted);
        errors++;
      end else begin
        x = pending_q.pop_front();
        if (out_ciphertext !== x.c) begin
          $display("%0t: ciphertext exp %h got %h", $time, x.c, out_ciphertext);
          errors++;
        end
        if (out_decrypted !== x.m) begin
          $display("%0t: decrypted exp %h got %h", $time, x.m, out_decrypted);
          errors++;
        end
      end
    end
  end

  initial begin
    #400ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    key_row_t       dir_rows[$];
    rsa_pair_t      typed;
    rsa_pkg::word_t ones;
    rsa_pkg::word_t n, e, d, msg;
    int             r;
    ones = '1;
    // reset key: n=1, e=d=0 gives 1,1 for anything
    dir_rows.push_back('{0, 64'd1, 0, 0, 64'd0, 1, 64'd1, 64'd1});
    dir_rows.push_back('{0, 64'd1, 0, 0, ones, 1, 64'd1, 64'd1});
    dir_rows.push_back('{1, 64'd1, 64'd1, 64'd1, 64'd5, 1, 64'd0, 64'd0});
    dir_rows.push_back('{1, 64'd0, 64'd1, 64'd1, ones, 1, ones, ones});
    dir_rows.push_back('{1, 64'd0, 64'd2, 64'd0, 64'd3, 1, 64'd9, 64'd1});
    dir_rows.push_back('{0, 64'd0, 64'd2, 64'd0, ones, 1, 64'd1, 64'd1});
    dir_rows.push_back('{1, 64'd0, 64'd0, 64'd5, 64'h1234, 1, 64'd1, 64'd1});
    dir_rows.push_back('{1, 64'd3233, 64'd17, 64'd2753, 64'd65, 1, 64'd2790, 64'd65});
    // message above the modulus is reduced first
    dir_rows.push_back('{0, 64'd3233, 64'd17, 64'd2753, 64'd3298, 1, 64'd2790, 64'd65});
    dir_rows.push_back('{0, 64'd3233, 64'd17, 64'd2753, 64'd0, 1, 64'd0, 64'd0});
    dir_rows.push_back('{0, 64'd3233, 64'd17, 64'd2753, ones, 0, 0, 0});
    dir_rows.push_back('{1, ones, ones, ones, 64'h8000_0000_0000_0001, 0, 0, 0});
    dir_rows.push_back('{0, ones, ones, ones, ones - 1, 0, 0, 0});
    dir_rows.push_back('{1, 64'h8000_0000_0000_0000, 64'd65537, 64'd3, ones, 0, 0, 0});
    dir_rows.push_back('{0, 64'h8000_0000_0000_0000, 64'd65537, 64'd3, 64'd2, 0, 0, 0});
    dir_rows.push_back('{1, 64'd2, 64'd1, 64'd0, 64'd7, 1, 64'd1, 64'd1});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].rekey) begin
        @(negedge clk);
        in_valid <= 1'b0;
        load_key(dir_rows[i].n, dir_rows[i].e, dir_rows[i].d);
      end
      typed.c = dir_rows[i].c;
      typed.m = dir_rows[i].m;
      send_msg(dir_rows[i].msg, dir_rows[i].known, typed);
    end

    for (int ph = 0; ph < 9; ph++) begin
      r = $urandom_range(0, 9);
      n = {$urandom(), $urandom()};
      if (r == 0) n = '0;
      else if (r == 1) n = ones;
      else if (r == 2) n = 64'($urandom_range(1, 50));
      else if (r == 3) n = 64'd1;
      // long exponents are slow: keep them to a couple of phases
      if (ph == 4 || ph == 7) begin
        e = {$urandom(), $urandom()};
        d = {$urandom(), $urandom()};
      end else begin
        e = 64'($urandom_range(0, 65535));
        d = 64'($urandom_range(0, 4095));
      end
      calm = (ph == 2);
      @(negedge clk);
      in_valid <= 1'b0;
      load_key(n, e, d);
      for (int k = 0; k < ((ph == 4 || ph == 7) ? 4 : 11); k++) begin
        r = $urandom_range(0, 9);
        msg = {$urandom(), $urandom()};
        if (r == 0) msg = '0;
        else if (r == 1) msg = ones;
        else if (r == 2) msg = n + 64'($urandom_range(0, 3));
        send_msg(msg, 1'b0, typed);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    calm = 1'b1;

    wait (pending_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

FILE: rsa_modexp_encrypt_decrypt_unit.f
hdl/rsa_pkg.sv
hdl/rsa_front.sv
hdl/rsa_mulmod.sv
hdl/rsa_engine.sv
hdl/rsa_modexp_encrypt_decrypt_unit.sv
dv/tb_rsa_modexp_encrypt_decrypt_unit.sv
